@@ hw/rtl/chgc_pkg.sv @@
package chgc_pkg;

  localparam int CELL_COUNT = 4096;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int ROOT_DEPTH = 1024;
  localparam int ROOT_W     = $clog2(ROOT_DEPTH);
  localparam int SLOT_W     = 11;

  localparam logic [31:0] WORD_NIL = 32'd3;
  localparam logic [31:0] WORD_ERR = 32'd11;
  localparam logic [31:0] LIST_END = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_RHEAD  = 3'd1;
  localparam logic [2:0] OP_RTAIL  = 3'd2;
  localparam logic [2:0] OP_WHEAD  = 3'd3;
  localparam logic [2:0] OP_WTAIL  = 3'd4;
  localparam logic [2:0] OP_PUSH   = 3'd5;
  localparam logic [2:0] OP_RSET   = 3'd6;
  localparam logic [2:0] OP_TRUNC  = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_NOCELL = 2'd2;
  localparam logic [1:0] ST_ROOT   = 2'd3;

  localparam logic CFG_GC_ENABLE   = 1'b0;
  localparam logic CFG_GLOBAL_ROOT = 1'b1;

  function automatic logic is_heap_ref(input logic [31:0] w);
    return (w[1:0] == 2'b01) && ((w >> 2) < 32'(CELL_COUNT));
  endfunction

endpackage

@@ hw/rtl/cons_heap_mark_sweep_collector.sv @@
// Pair-cell heap engine with mark-sweep collection. Writes, root operations and
// allocations from the bump pointer go from the execute state straight to the
// done state. Reads and allocations from the free list pass through one more
// wait state, because they add one synchronous memory read. A collection runs
// when allocation finds no free cell and gc_enable is set. It clears the mark
// bits and marks the pending pair and the global root. It marks each live root
// stack entry, traces every marked cell and sweeps the heap. The input stalls
// throughout. Each accepted transaction gives exactly one result transaction,
// held in an output register. The input stays stalled until that result is
// taken.
module cons_heap_mark_sweep_collector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_cell_ref,
  input  logic [31:0] in_head_value,
  input  logic [31:0] in_tail_value,
  input  logic [10:0] in_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_out_of_memory,
  output logic [31:0] out_collections
);

  localparam int CW = chgc_pkg::CELL_W;
  localparam int RW = chgc_pkg::ROOT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_POPWAIT, S_ROOTWAIT,
    S_CLR, S_MPEND, S_MROOT_RD, S_MROOT_WT, S_MWORD,
    S_TPOP, S_TRD, S_TWT, S_THEAD, S_TTAIL,
    S_SWP, S_SWPWT, S_POSTGC, S_DONE
  } state_t;

  state_t state_r;

  logic [31:0] heap_h [chgc_pkg::CELL_COUNT];
  logic [31:0] heap_t [chgc_pkg::CELL_COUNT];
  logic        mark_m [chgc_pkg::CELL_COUNT];
  logic [CW-1:0] mstk  [chgc_pkg::CELL_COUNT];
  logic [31:0] rstk   [chgc_pkg::ROOT_DEPTH];

  logic [31:0] h_rd_r, t_rd_r, r_rd_r;
  logic        m_rd_r;
  logic [CW-1:0] ms_rd_r;

  logic        gc_en_r;
  logic [31:0] groot_r;
  logic [2:0]  op_r;
  logic [31:0] ref_r, hv_r, tv_r;
  logic [10:0] slot_r;
  logic [CW:0] bump_r;
  logic [CW-1:0] fhead_r;
  logic        fvalid_r;
  logic [RW:0] rdepth_r;
  logic        oom_r;
  logic [31:0] coll_r;
  logic        tried_gc_r;
  logic [CW:0] cnt_r;
  logic [CW:0] mtop_r;
  logic [RW:0] ridx_r;
  logic [31:0] mword_r;
  logic [1:0]  mret_r;
  logic [31:0] link_r;
  logic [CW-1:0] cur_r;

  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [1:0]  out_status_r;

  logic accept;
  logic [CW-1:0] ref_idx;
  logic ref_ok;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign accept = in_valid && !in_stall;
  assign ref_idx = ref_r[CW+1:2];
  assign ref_ok = chgc_pkg::is_heap_ref(ref_r) && ((ref_r >> 2) < 32'(bump_r));

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_status = out_status_r;
  assign out_out_of_memory = oom_r;
  assign out_collections = coll_r;

  // Memory ports: one address per memory, chosen by state.
  logic          h_we, t_we, m_we, ms_we, r_we;
  logic [CW-1:0] h_a, t_a, m_a, ms_a;
  logic [RW-1:0] r_a;
  logic [31:0]   h_wd, t_wd, r_wd;
  logic          m_wd;
  logic [CW-1:0] ms_wd;
  logic [CW-1:0] mw_idx;
  assign mw_idx = mword_r[CW+1:2];

  always_comb begin
    h_we = 1'b0; t_we = 1'b0; m_we = 1'b0; ms_we = 1'b0; r_we = 1'b0;
    h_a = ref_idx; t_a = ref_idx; m_a = cnt_r[CW-1:0]; ms_a = mtop_r[CW-1:0];
    r_a = rdepth_r[RW-1:0];
    h_wd = hv_r; t_wd = hv_r; r_wd = hv_r; m_wd = 1'b0; ms_wd = mw_idx;
    unique case (state_r)
      S_EXEC: begin
        if (op_r == chgc_pkg::OP_ALLOC && bump_r < (CW+1)'(chgc_pkg::CELL_COUNT)) begin
          h_we = 1'b1; t_we = 1'b1; h_a = bump_r[CW-1:0]; t_a = bump_r[CW-1:0];
          t_wd = tv_r;
        end else if (op_r == chgc_pkg::OP_ALLOC) begin
          t_a = fhead_r;
        end else if (op_r == chgc_pkg::OP_WHEAD && ref_ok) begin
          h_we = 1'b1;
        end else if (op_r == chgc_pkg::OP_WTAIL && ref_ok) begin
          t_we = 1'b1;
        end else if (op_r == chgc_pkg::OP_PUSH
                     && rdepth_r < (RW+1)'(chgc_pkg::ROOT_DEPTH)) begin
          r_we = 1'b1;
        end else if (op_r == chgc_pkg::OP_RSET
                     && {1'b0, slot_r} < 12'(rdepth_r)) begin
          r_we = 1'b1; r_a = slot_r[RW-1:0];
        end
      end
      S_POPWAIT: begin
        h_we = 1'b1; t_we = 1'b1; h_a = fhead_r; t_a = fhead_r; t_wd = tv_r;
      end
      S_CLR: m_we = 1'b1;
      S_MPEND: m_a = mw_idx;
      S_MROOT_RD: r_a = ridx_r[RW-1:0];
      S_MWORD: begin
        m_a = mw_idx;
        if (chgc_pkg::is_heap_ref(mword_r) && !m_rd_r) begin
          m_we = 1'b1; m_wd = 1'b1; ms_we = 1'b1;
        end
      end
      S_TPOP: ms_a = mtop_r[CW-1:0] - 1'b1;
      S_TRD: begin h_a = ms_rd_r; t_a = ms_rd_r; end
      S_SWP: m_a = cnt_r[CW-1:0];
      S_SWPWT: begin
        t_a = cnt_r[CW-1:0]; t_wd = link_r; t_we = !m_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_h[h_a] <= h_wd;
    h_rd_r <= heap_h[h_a];
    if (t_we) heap_t[t_a] <= t_wd;
    t_rd_r <= heap_t[t_a];
    if (m_we) mark_m[m_a] <= m_wd;
    m_rd_r <= mark_m[m_a];
    if (ms_we) mstk[ms_a] <= ms_wd;
    ms_rd_r <= mstk[ms_a];
    if (r_we) rstk[r_a] <= r_wd;
    r_rd_r <= rstk[r_a];
  end

  // Finish an operation with a result.
  logic [31:0] nx_val;
  logic [1:0]  nx_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gc_en_r <= 1'b0;
      groot_r <= chgc_pkg::WORD_NIL;
      bump_r <= '0;
      fhead_r <= '0;
      fvalid_r <= 1'b0;
      rdepth_r <= '0;
      oom_r <= 1'b0;
      coll_r <= '0;
      out_valid_r <= 1'b0;
      tried_gc_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          chgc_pkg::CFG_GC_ENABLE:   gc_en_r <= cfg_wdata[0];
          chgc_pkg::CFG_GLOBAL_ROOT: groot_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r <= in_op; ref_r <= in_cell_ref; hv_r <= in_head_value;
            tv_r <= in_tail_value; slot_r <= in_slot; tried_gc_r <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_r)
            chgc_pkg::OP_ALLOC: begin
              if (bump_r < (CW+1)'(chgc_pkg::CELL_COUNT)) begin
                out_value_r <= {{(30-CW){1'b0}}, bump_r[CW-1:0], 2'b01};
                out_status_r <= chgc_pkg::ST_OK;
                bump_r <= bump_r + 1'b1;
                state_r <= S_DONE;
              end else if (fvalid_r) begin
                out_status_r <= chgc_pkg::ST_OK;
                state_r <= S_POPWAIT;
              end else if (gc_en_r && !tried_gc_r) begin
                tried_gc_r <= 1'b1;
                coll_r <= coll_r + 1'b1;
                cnt_r <= '0;
                state_r <= S_CLR;
              end else begin
                oom_r <= 1'b1;
                out_value_r <= chgc_pkg::WORD_ERR;
                out_status_r <= chgc_pkg::ST_OOM;
                state_r <= S_DONE;
              end
            end
            chgc_pkg::OP_RHEAD, chgc_pkg::OP_RTAIL: begin
              if (ref_ok) begin
                out_status_r <= chgc_pkg::ST_OK; state_r <= S_RDWAIT;
              end else begin
                out_value_r <= chgc_pkg::WORD_ERR; out_status_r <= chgc_pkg::ST_NOCELL;
                state_r <= S_DONE;
              end
            end
            chgc_pkg::OP_WHEAD, chgc_pkg::OP_WTAIL: begin
              state_r <= S_DONE;
              if (ref_ok) begin
                out_value_r <= hv_r; out_status_r <= chgc_pkg::ST_OK;
              end else begin
                out_value_r <= chgc_pkg::WORD_ERR; out_status_r <= chgc_pkg::ST_NOCELL;
              end
            end
            chgc_pkg::OP_PUSH: begin
              state_r <= S_DONE;
              if (rdepth_r < (RW+1)'(chgc_pkg::ROOT_DEPTH)) begin
                rdepth_r <= rdepth_r + 1'b1; out_value_r <= hv_r;
                out_status_r <= chgc_pkg::ST_OK;
              end else begin
                out_value_r <= chgc_pkg::WORD_ERR; out_status_r <= chgc_pkg::ST_ROOT;
              end
            end
            chgc_pkg::OP_RSET: begin
              state_r <= S_DONE;
              if ({1'b0, slot_r} < 12'(rdepth_r)) begin
                out_value_r <= hv_r; out_status_r <= chgc_pkg::ST_OK;
              end else begin
                out_value_r <= chgc_pkg::WORD_ERR; out_status_r <= chgc_pkg::ST_ROOT;
              end
            end
            default: begin
              state_r <= S_DONE;
              if ({1'b0, slot_r} <= 12'(rdepth_r)) begin
                rdepth_r <= (RW+1)'(slot_r); out_value_r <= {21'd0, slot_r};
                out_status_r <= chgc_pkg::ST_OK;
              end else begin
                out_value_r <= chgc_pkg::WORD_ERR; out_status_r <= chgc_pkg::ST_ROOT;
              end
            end
          endcase
        end
        S_RDWAIT: begin
          out_value_r <= (op_r == chgc_pkg::OP_RHEAD) ? h_rd_r : t_rd_r;
          state_r <= S_DONE;
        end
        S_POPWAIT: begin
          // Tail read of the free head gives the link; the cell is written now.
          out_value_r <= {{(30-CW){1'b0}}, fhead_r, 2'b01};
          if (t_rd_r < 32'(chgc_pkg::CELL_COUNT)) fhead_r <= t_rd_r[CW-1:0];
          else begin fhead_r <= '0; fvalid_r <= 1'b0; end
          state_r <= S_DONE;
        end
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (CW+1)'(chgc_pkg::CELL_COUNT - 1)) begin
            mtop_r <= '0; mword_r <= hv_r; mret_r <= 2'd0;
            state_r <= S_MPEND;
          end
        end
        S_MPEND: state_r <= S_MWORD;  // mark bit read of mword_r in flight
        S_MWORD: begin
          if (chgc_pkg::is_heap_ref(mword_r) && !m_rd_r) mtop_r <= mtop_r + 1'b1;
          unique case (mret_r)
            2'd0: begin
              // The pending head, the pending tail and the global root go in turn,
              // with cnt_r as the step.
              if (cnt_r == (CW+1)'(chgc_pkg::CELL_COUNT)) begin
                mword_r <= tv_r; cnt_r <= (CW+1)'(1); state_r <= S_MPEND;
              end else if (cnt_r == (CW+1)'(1)) begin
                mword_r <= groot_r; cnt_r <= (CW+1)'(2); state_r <= S_MPEND;
              end else begin
                ridx_r <= '0; mret_r <= 2'd1; state_r <= S_MROOT_RD;
              end
            end
            2'd1: begin
              ridx_r <= ridx_r + 1'b1; state_r <= S_MROOT_RD;
            end
            2'd2: begin
              mword_r <= link_r; mret_r <= 2'd3; state_r <= S_MPEND;
            end
            default: state_r <= S_TPOP;
          endcase
        end
        S_MROOT_RD: begin
          if (ridx_r < rdepth_r) state_r <= S_MROOT_WT;
          else state_r <= S_TPOP;
        end
        S_MROOT_WT: begin
          mword_r <= r_rd_r; state_r <= S_MPEND;
        end
        S_TPOP: begin
          if (mtop_r == '0) begin
            cnt_r <= '0; link_r <= chgc_pkg::LIST_END; fvalid_r <= 1'b0;
            fhead_r <= '0; state_r <= S_SWP;
          end else begin
            mtop_r <= mtop_r - 1'b1; state_r <= S_TRD;
          end
        end
        S_TRD: state_r <= S_THEAD;
        S_THEAD: begin
          // The tail word waits in link_r while the head word is marked.
          mword_r <= h_rd_r; link_r <= t_rd_r; mret_r <= 2'd2; state_r <= S_MPEND;
        end
        S_SWP: state_r <= S_SWPWT;
        S_SWPWT: begin
          if (!m_rd_r) begin
            link_r <= {{(32-CW){1'b0}}, cnt_r[CW-1:0]};
            fhead_r <= cnt_r[CW-1:0]; fvalid_r <= 1'b1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (CW+1)'(chgc_pkg::CELL_COUNT - 1)) state_r <= S_POSTGC;
          else state_r <= S_SWP;
        end
        S_POSTGC: state_r <= S_EXEC;
        S_DONE: begin
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign nx_val = out_value_r;
  assign nx_st = out_status_r;

  property p_err_value;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && nx_st != chgc_pkg::ST_OK) |-> (nx_val == chgc_pkg::WORD_ERR);
  endproperty
  a_err_value: assert property (p_err_value) else $error("error result without ERR");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");

  a_oom_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(oom_r) |-> oom_r) else $error("oom flag cleared");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rdepth_r <= (RW+1)'(chgc_pkg::ROOT_DEPTH)) else $error("root depth overflow");

endmodule
